@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the morph target blend block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define MTB_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MTB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/mtb_pkg.sv @@
// ----------------------------------------------------------------------------
// mtb_pkg
// types, widths and codes of the morph target blend block
// ----------------------------------------------------------------------------
`default_nettype none

package mtb_pkg;

    localparam int MAX_TARGETS  = 8;
    localparam int MAX_VERTICES = 4096;
    localparam int TGT_W        = $clog2(MAX_TARGETS);
    localparam int VTX_W        = $clog2(MAX_VERTICES);
    localparam int ADDR_W       = TGT_W + VTX_W;
    localparam int STORE_DEPTH  = MAX_TARGETS * MAX_VERTICES;

    localparam int CNT_W        = 4;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 4;
    localparam int REQ_W        = 2;

    localparam int POS_W        = 18;
    localparam int NRM_W        = 16;
    localparam int WGT_W        = 16;
    localparam int FRAC         = 14;
    localparam int DELTA_W      = 3 * POS_W + 3 * NRM_W;

    localparam int PPROD_W      = WGT_W + POS_W;
    localparam int NPROD_W      = WGT_W + NRM_W;
    localparam int PACC_W       = 40;
    localparam int NACC_W       = 37;
    localparam int NR_W         = 21;

    localparam int MAG_W        = NR_W;
    localparam int SQ_W         = 2 * MAG_W;
    localparam int SUM_W        = SQ_W + 2;
    localparam int RAD_SHIFT    = 20;
    localparam int RAD_W        = SUM_W + RAD_SHIFT;
    localparam int ROOT_W       = RAD_W / 2;
    localparam int REM_W        = ROOT_W + 2;
    localparam int IT_W         = $clog2(ROOT_W);
    localparam int NUM_SHIFT    = 24;
    localparam int DIV_W        = MAG_W + NUM_SHIFT + 1;
    localparam int Q_W          = NRM_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_WEIGHT = 2'd0,
        REQ_DELTA  = 2'd1,
        REQ_BLEND  = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    localparam logic [CFG_IDX_W-1:0] CFG_TGT_CNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMALS = 1'd1;

    typedef struct packed {
        logic                   start;
        logic signed [NR_W-1:0] nr_x;
        logic signed [NR_W-1:0] nr_y;
        logic signed [NR_W-1:0] nr_z;
    } t_norm_in;

    typedef struct packed {
        logic                    done;
        logic signed [NRM_W-1:0] nrm_x;
        logic signed [NRM_W-1:0] nrm_y;
        logic signed [NRM_W-1:0] nrm_z;
    } t_norm_out;

endpackage

`default_nettype wire

@@ rtl/core/mtb_ifs.sv @@
// ----------------------------------------------------------------------------
// mtb_ifs
// request, result and configuration channels of the morph target blend block
// ----------------------------------------------------------------------------
`default_nettype none

interface mtb_req_if import mtb_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [REQ_W-1:0]         req_type;
    logic [TGT_W-1:0]         target_index;
    logic [VTX_W-1:0]         vertex_index;
    logic signed [WGT_W-1:0]  weight_value;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic signed [NRM_W-1:0]  nrm_x;
    logic signed [NRM_W-1:0]  nrm_y;
    logic signed [NRM_W-1:0]  nrm_z;
    logic                     last_vertex;

    modport source (output valid, req_type, target_index, vertex_index, weight_value,
                    pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, last_vertex,
                    input ready);
    modport sink (input valid, req_type, target_index, vertex_index, weight_value,
                  pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, last_vertex,
                  output ready);
endinterface

interface mtb_res_if import mtb_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [VTX_W-1:0]         vertex_out;
    logic signed [POS_W-1:0]  out_pos_x;
    logic signed [POS_W-1:0]  out_pos_y;
    logic signed [POS_W-1:0]  out_pos_z;
    logic signed [NRM_W-1:0]  out_nrm_x;
    logic signed [NRM_W-1:0]  out_nrm_y;
    logic signed [NRM_W-1:0]  out_nrm_z;
    logic                     normal_valid;
    logic                     last_out;

    modport source (output valid, vertex_out, out_pos_x, out_pos_y, out_pos_z,
                    out_nrm_x, out_nrm_y, out_nrm_z, normal_valid, last_out,
                    input ready);
    modport sink (input valid, vertex_out, out_pos_x, out_pos_y, out_pos_z,
                  out_nrm_x, out_nrm_y, out_nrm_z, normal_valid, last_out,
                  output ready);
endinterface

interface mtb_cfg_if import mtb_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/mtb_norm.sv @@
// ----------------------------------------------------------------------------
// mtb_norm
// normal renormalizer: squares, bit-pair square root, three long dividers
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mtb_norm import mtb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_norm_in  i_ctl,
    output t_norm_out o_sts
);

    typedef enum logic [2:0] {
        N_IDLE, N_SQ, N_SUM, N_SQRT, N_PREP, N_DIV, N_SIGN
    } t_state;

    t_state                   r_state;
    logic                     r_done;
    logic [IT_W-1:0]          r_cnt;
    logic signed [NR_W-1:0]   r_nr   [3];
    logic [MAG_W-1:0]         r_mag  [3];
    logic                     r_neg  [3];
    logic [SQ_W-1:0]          r_sq   [3];
    logic [RAD_W-1:0]         r_rad;
    logic [REM_W-1:0]         r_rem;
    logic [ROOT_W-1:0]        r_root;
    logic [ROOT_W-1:0]        r_drem [3];
    logic [Q_W-1:0]           r_dlow [3];
    logic [Q_W-1:0]           r_q    [3];
    logic signed [NRM_W-1:0]  r_res  [3];

    logic signed [NR_W-1:0]   in_nr  [3];
    logic [REM_W+1:0]         rem_sh;
    logic [REM_W+1:0]         trial;
    logic                     sq_ge;
    logic [REM_W-1:0]         n_rem;
    logic [ROOT_W-1:0]        n_root;
    logic [DIV_W-1:0]         dividend [3];
    logic [ROOT_W:0]          dv_t   [3];
    logic                     dv_ge  [3];
    logic [ROOT_W-1:0]        n_drem [3];

    function automatic logic signed [NRM_W-1:0] sat_nr(input logic signed [NR_W-1:0] v);
        logic signed [NRM_W-1:0] r;
        if (&v[NR_W-1:NRM_W-1] || ~|v[NR_W-1:NRM_W-1]) begin
            r = v[NRM_W-1:0];
        end else if (v[NR_W-1]) begin
            r = {1'b1, {(NRM_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(NRM_W-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic signed [NRM_W-1:0] signed_q(input logic [Q_W-1:0] q,
                                                        input logic neg);
        logic signed [NRM_W-1:0] r;
        if (!neg) begin
            r = q[Q_W-1] ? {1'b0, {(NRM_W-1){1'b1}}} : $signed(q);
        end else if (q[Q_W-1] && |q[Q_W-2:0]) begin
            r = {1'b1, {(NRM_W-1){1'b0}}};
        end else begin
            r = $signed(-q);
        end
        return r;
    endfunction

    assign in_nr[0] = i_ctl.nr_x;
    assign in_nr[1] = i_ctl.nr_y;
    assign in_nr[2] = i_ctl.nr_z;

    always_comb begin
        rem_sh = {r_rem, r_rad[RAD_W-1 -: 2]};
        trial  = (REM_W+2)'({r_root, 2'b01});
        sq_ge  = rem_sh >= trial;
        n_rem  = sq_ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
        n_root = {r_root[ROOT_W-2:0], sq_ge};
        for (int i = 0; i < 3; i++) begin
            dividend[i] = DIV_W'({r_mag[i], {NUM_SHIFT{1'b0}}}) + DIV_W'(r_root >> 1);
            dv_t[i]     = {r_drem[i], r_dlow[i][Q_W-1]};
            dv_ge[i]    = dv_t[i] >= {1'b0, r_root};
            n_drem[i]   = dv_ge[i] ? ROOT_W'(dv_t[i] - {1'b0, r_root}) : ROOT_W'(dv_t[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                N_IDLE: begin
                    if (i_ctl.start) begin
                        r_state <= N_SQ;
                    end
                end
                N_SQ: begin
                    r_state <= N_SUM;
                end
                N_SUM: begin
                    r_cnt   <= IT_W'(ROOT_W - 1);
                    r_state <= N_SQRT;
                end
                N_SQRT: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= N_PREP;
                    end
                end
                N_PREP: begin
                    r_cnt <= IT_W'(Q_W - 1);
                    if (r_root == '0) begin
                        r_done  <= 1'b1;
                        r_state <= N_IDLE;
                    end else begin
                        r_state <= N_DIV;
                    end
                end
                N_DIV: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= N_SIGN;
                    end
                end
                N_SIGN: begin
                    r_done  <= 1'b1;
                    r_state <= N_IDLE;
                end
                default: begin
                    r_state <= N_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            N_IDLE: begin
                for (int i = 0; i < 3; i++) begin
                    r_nr[i]  <= in_nr[i];
                    r_neg[i] <= in_nr[i][NR_W-1];
                    r_mag[i] <= in_nr[i][NR_W-1] ? MAG_W'(-in_nr[i]) : MAG_W'(in_nr[i]);
                end
            end
            N_SQ: begin
                for (int i = 0; i < 3; i++) begin
                    r_sq[i] <= r_mag[i] * r_mag[i];
                end
            end
            N_SUM: begin
                r_rad  <= {SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]),
                           {RAD_SHIFT{1'b0}}};
                r_rem  <= '0;
                r_root <= '0;
            end
            N_SQRT: begin
                r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
                r_rem  <= n_rem;
                r_root <= n_root;
            end
            N_PREP: begin
                for (int i = 0; i < 3; i++) begin
                    r_drem[i] <= ROOT_W'(dividend[i][DIV_W-1:Q_W]);
                    r_dlow[i] <= dividend[i][Q_W-1:0];
                    r_q[i]    <= '0;
                    r_res[i]  <= sat_nr(r_nr[i]);
                end
            end
            N_DIV: begin
                for (int i = 0; i < 3; i++) begin
                    r_drem[i] <= n_drem[i];
                    r_dlow[i] <= {r_dlow[i][Q_W-2:0], 1'b0};
                    r_q[i]    <= {r_q[i][Q_W-2:0], dv_ge[i]};
                end
            end
            N_SIGN: begin
                for (int i = 0; i < 3; i++) begin
                    r_res[i] <= signed_q(r_q[i], r_neg[i]);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_sts.done  = r_done;
    assign o_sts.nrm_x = r_res[0];
    assign o_sts.nrm_y = r_res[1];
    assign o_sts.nrm_z = r_res[2];

    `MTB_ASSERT(a_div_len_nonzero, i_clk, i_rst_n, r_state == N_DIV, r_root != '0,
        "division by zero length")
    `MTB_ASSERT_NEXT(a_start_from_idle, i_clk, i_rst_n, i_ctl.start, r_state == N_SQ,
        "start while busy")
    `MTB_ASSERT(a_done_in_idle, i_clk, i_rst_n, r_done, r_state == N_IDLE,
        "done outside idle")

endmodule

`default_nettype wire

@@ rtl/core/morph_target_blend_core.sv @@
// ----------------------------------------------------------------------------
// morph_target_blend_core
// morph target vertex blender: weight table, delta memory, normal renormalizer
//
//   channel   dir   modport   carries
//   i_cfg     in    sink      target count, normals enable writes
//   i_req     in    sink      weight write, delta write, blend request
//   o_res     out   source    one blended vertex per blend request
//
//   blend: one delta memory read per target in use, then, when normals are
//   enabled, the renormalizer (32-step square root, 16-step division, the
//   division skipped for a zero-length normal); one request in flight
//   synchronous active-low reset clears weights and control registers, not the deltas
//   the result waits in an output register while the next request is taken
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module morph_target_blend_core import mtb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mtb_cfg_if.sink   i_cfg,
    mtb_req_if.sink   i_req,
    mtb_res_if.source o_res
);

    typedef enum logic [1:0] {S_IDLE, S_READ, S_NORM, S_OUT} t_state;

    localparam int PR_W = PACC_W - FRAC;
    localparam int NF_W = NACC_W - FRAC;
    localparam int ROUND_HALF = 1 << (FRAC - 1);

    t_state                    r_state;
    logic [CNT_W-1:0]          r_tgt_cnt;
    logic                      r_normals_en;
    logic signed [WGT_W-1:0]   r_weight [MAX_TARGETS];
    logic [CNT_W-1:0]          r_tn;
    logic [CNT_W-1:0]          r_issue;
    logic                      r_rd_vld;
    logic signed [WGT_W-1:0]   r_rd_w;
    logic                      r_prod_vld;
    logic                      r_norm_start;
    logic                      r_out_vld;

    logic [DELTA_W-1:0]        r_mem [STORE_DEPTH];
    logic [DELTA_W-1:0]        r_rd_data;

    logic [VTX_W-1:0]          r_vtx;
    logic                      r_last;
    logic signed [PACC_W-1:0]  r_pacc [3];
    logic signed [NACC_W-1:0]  r_nacc [3];
    logic signed [PPROD_W-1:0] r_pp   [3];
    logic signed [NPROD_W-1:0] r_np   [3];
    logic signed [POS_W-1:0]   r_pos  [3];
    logic signed [NR_W-1:0]    r_nr   [3];
    logic signed [NRM_W-1:0]   r_nrm  [3];

    logic [VTX_W-1:0]          r_o_vtx;
    logic signed [POS_W-1:0]   r_o_pos [3];
    logic signed [NRM_W-1:0]   r_o_nrm [3];
    logic                      r_o_nvalid;
    logic                      r_o_last;

    logic                      cfg_acc;
    logic                      req_acc;
    logic                      blend_acc;
    logic                      mem_we;
    logic [ADDR_W-1:0]         mem_wa;
    logic [ADDR_W-1:0]         mem_ra;
    logic                      issue;
    logic                      read_done;
    logic                      out_load;
    logic signed [WGT_W-1:0]   issue_w;
    logic signed [POS_W-1:0]   in_pos [3];
    logic signed [NRM_W-1:0]   in_nrm [3];
    logic signed [POS_W-1:0]   d_pos  [3];
    logic signed [NRM_W-1:0]   d_nrm  [3];
    logic signed [PACC_W-1:0]  p_rnd  [3];
    logic signed [NACC_W-1:0]  n_rnd  [3];
    logic signed [PR_W-1:0]    p_fl   [3];
    logic signed [NF_W-1:0]    n_fl   [3];
    logic signed [POS_W-1:0]   p_sat  [3];
    t_norm_in                  norm_ctl;
    t_norm_out                 norm_sts;

    assign cfg_acc   = i_cfg.valid && i_cfg.ready;
    assign req_acc   = i_req.valid && i_req.ready;
    assign blend_acc = req_acc && (i_req.req_type == REQ_BLEND);
    assign mem_we    = req_acc && (i_req.req_type == REQ_DELTA);
    assign mem_wa    = {i_req.target_index, i_req.vertex_index};
    assign mem_ra    = {r_issue[TGT_W-1:0], r_vtx};
    assign issue     = (r_state == S_READ) && (r_issue < r_tn);
    assign issue_w   = r_weight[r_issue[TGT_W-1:0]];
    assign read_done = (r_state == S_READ) && (r_issue == r_tn) && !r_rd_vld && !r_prod_vld;
    assign out_load  = (r_state == S_OUT) && (!r_out_vld || o_res.ready);

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == S_IDLE);

    assign in_pos[0] = i_req.pos_x;
    assign in_pos[1] = i_req.pos_y;
    assign in_pos[2] = i_req.pos_z;
    assign in_nrm[0] = i_req.nrm_x;
    assign in_nrm[1] = i_req.nrm_y;
    assign in_nrm[2] = i_req.nrm_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d_pos[i] = $signed(r_rd_data[DELTA_W-1-i*POS_W -: POS_W]);
            d_nrm[i] = $signed(r_rd_data[3*NRM_W-1-i*NRM_W -: NRM_W]);
            p_rnd[i] = r_pacc[i] + PACC_W'(ROUND_HALF);
            n_rnd[i] = r_nacc[i] + NACC_W'(ROUND_HALF);
            p_fl[i]  = $signed(p_rnd[i][PACC_W-1:FRAC]);
            n_fl[i]  = $signed(n_rnd[i][NACC_W-1:FRAC]);
            if (&p_fl[i][PR_W-1:POS_W-1] || ~|p_fl[i][PR_W-1:POS_W-1]) begin
                p_sat[i] = p_fl[i][POS_W-1:0];
            end else if (p_fl[i][PR_W-1]) begin
                p_sat[i] = {1'b1, {(POS_W-1){1'b0}}};
            end else begin
                p_sat[i] = {1'b0, {(POS_W-1){1'b1}}};
            end
        end
    end

    // delta memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= {i_req.pos_x, i_req.pos_y, i_req.pos_z,
                              i_req.nrm_x, i_req.nrm_y, i_req.nrm_z};
        end
        r_rd_data <= r_mem[mem_ra];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_tgt_cnt    <= '0;
            r_normals_en <= 1'b0;
            r_tn         <= '0;
            r_issue      <= '0;
            r_rd_vld     <= 1'b0;
            r_prod_vld   <= 1'b0;
            r_norm_start <= 1'b0;
            r_out_vld    <= 1'b0;
            for (int i = 0; i < MAX_TARGETS; i++) begin
                r_weight[i] <= '0;
            end
        end else begin
            r_norm_start <= 1'b0;
            r_rd_vld     <= issue && (issue_w != '0);
            r_prod_vld   <= r_rd_vld;
            if (cfg_acc) begin
                case (i_cfg.index)
                    CFG_TGT_CNT: r_tgt_cnt    <= i_cfg.data[CNT_W-1:0];
                    CFG_NORMALS: r_normals_en <= i_cfg.data[0];
                    default: begin
                    end
                endcase
            end
            if (o_res.valid && o_res.ready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (req_acc) begin
                        case (i_req.req_type)
                            REQ_WEIGHT: r_weight[i_req.target_index] <= i_req.weight_value;
                            REQ_BLEND: begin
                                r_issue <= '0;
                                r_tn    <= (r_tgt_cnt > CNT_W'(MAX_TARGETS)) ?
                                           CNT_W'(MAX_TARGETS) : r_tgt_cnt;
                                r_state <= S_READ;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_READ: begin
                    if (issue) begin
                        r_issue <= r_issue + 1'b1;
                    end
                    if (read_done) begin
                        if (r_normals_en) begin
                            r_norm_start <= 1'b1;
                            r_state      <= S_NORM;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_NORM: begin
                    if (norm_sts.done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_out_vld <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_rd_w <= issue_w;
        for (int i = 0; i < 3; i++) begin
            r_pp[i] <= r_rd_w * d_pos[i];
            r_np[i] <= r_rd_w * d_nrm[i];
        end
        if (blend_acc) begin
            r_vtx  <= i_req.vertex_index;
            r_last <= i_req.last_vertex;
            for (int i = 0; i < 3; i++) begin
                r_pacc[i] <= PACC_W'(in_pos[i]) <<< FRAC;
                r_nacc[i] <= NACC_W'(in_nrm[i]) <<< FRAC;
            end
        end else if (r_prod_vld) begin
            for (int i = 0; i < 3; i++) begin
                r_pacc[i] <= r_pacc[i] + PACC_W'(r_pp[i]);
                r_nacc[i] <= r_nacc[i] + NACC_W'(r_np[i]);
            end
        end
        if (read_done) begin
            for (int i = 0; i < 3; i++) begin
                r_pos[i] <= p_sat[i];
                r_nr[i]  <= n_fl[i][NR_W-1:0];
                r_nrm[i] <= '0;
            end
        end
        if ((r_state == S_NORM) && norm_sts.done) begin
            r_nrm[0] <= norm_sts.nrm_x;
            r_nrm[1] <= norm_sts.nrm_y;
            r_nrm[2] <= norm_sts.nrm_z;
        end
        if (out_load) begin
            r_o_vtx    <= r_vtx;
            r_o_nvalid <= r_normals_en;
            r_o_last   <= r_last;
            for (int i = 0; i < 3; i++) begin
                r_o_pos[i] <= r_pos[i];
                r_o_nrm[i] <= r_normals_en ? r_nrm[i] : '0;
            end
        end
    end

    assign norm_ctl.start = r_norm_start;
    assign norm_ctl.nr_x  = r_nr[0];
    assign norm_ctl.nr_y  = r_nr[1];
    assign norm_ctl.nr_z  = r_nr[2];

    mtb_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (norm_ctl),
        .o_sts   (norm_sts)
    );

    assign o_res.valid        = r_out_vld;
    assign o_res.vertex_out   = r_o_vtx;
    assign o_res.out_pos_x    = r_o_pos[0];
    assign o_res.out_pos_y    = r_o_pos[1];
    assign o_res.out_pos_z    = r_o_pos[2];
    assign o_res.out_nrm_x    = r_o_nrm[0];
    assign o_res.out_nrm_y    = r_o_nrm[1];
    assign o_res.out_nrm_z    = r_o_nrm[2];
    assign o_res.normal_valid = r_o_nvalid;
    assign o_res.last_out     = r_o_last;

    `MTB_ASSERT(a_idle_pipe_empty, i_clk, i_rst_n, r_state == S_IDLE,
        !r_rd_vld && !r_prod_vld, "read pipeline busy in idle")
    `MTB_ASSERT(a_norm_done_state, i_clk, i_rst_n, norm_sts.done, r_state == S_NORM,
        "renormalizer done outside wait")
    `MTB_ASSERT_NEXT(a_load_sets_valid, i_clk, i_rst_n, out_load,
        r_out_vld && (r_state == S_IDLE), "result load lost")

endmodule

`default_nettype wire
